FILE: design/cst_pkg.sv
// shared types, constants and helpers for the csv stream tokenizer
package cst_pkg;

	localparam int HOLD_DEPTH     = 16;
	localparam int RUN_COUNT_BITS = 16;
	localparam int HOLD_AW        = $clog2(HOLD_DEPTH);
	localparam int HOLD_CW        = HOLD_AW + 1;
	localparam int RUN_W          = 16;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

	localparam logic [RUN_W-1:0] RUN_MAX =
		(RUN_COUNT_BITS >= RUN_W) ? {RUN_W{1'b1}} : RUN_W'((64'd1 << RUN_COUNT_BITS) - 64'd1);

	localparam logic [7:0] BOM_0   = 8'hEF;
	localparam logic [7:0] BOM_1   = 8'hBB;
	localparam logic [7:0] BOM_2   = 8'hBF;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [1:0] CFG_SEP  = 2'd0;
	localparam logic [1:0] CFG_TRIM = 2'd1;
	localparam logic [1:0] CFG_HDR  = 2'd2;
	localparam logic [1:0] CFG_SKIP = 2'd3;

	localparam logic [2:0] KIND_BYTE  = 3'd0;
	localparam logic [2:0] KIND_CELL  = 3'd1;
	localparam logic [2:0] KIND_REC   = 3'd2;
	localparam logic [2:0] KIND_RUN   = 3'd3;
	localparam logic [2:0] KIND_OPENQ = 3'd4;
	localparam logic [2:0] KIND_OVF   = 3'd5;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic       quote;
		logic       sep;
		logic       lf;
		logic       cr;
		logic       ws;
	} entry_t;

	typedef struct packed {
		logic trim;
		logic hdr;
		logic skip;
	} cfg_t;

	function automatic logic is_ws(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
			c == CH_FF || c == CH_VT;
	endfunction

endpackage

FILE: design/cst_front.sv
// front end: classifies input beats and queues them for the sequencer
module cst_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_tuser,
	input  logic [7:0]          sep,
	output logic                head_valid,
	output cst_pkg::entry_t     head,
	input  logic                pop
);

	cst_pkg::entry_t                 q_q [cst_pkg::QUEUE_DEPTH];
	logic [cst_pkg::QUEUE_AW-1:0]    wp_q;
	logic [cst_pkg::QUEUE_AW-1:0]    rp_q;
	logic [cst_pkg::QUEUE_AW:0]      cnt_q;
	cst_pkg::entry_t                 ent;
	logic                            push;
	logic                            do_pop;

	assign s_tready   = cnt_q != (cst_pkg::QUEUE_AW+1)'(cst_pkg::QUEUE_DEPTH);
	assign push       = s_tvalid && s_tready;
	assign head_valid = cnt_q != '0;
	assign do_pop     = pop && head_valid;
	assign head       = q_q[rp_q];

	always_comb begin
		ent.ch    = s_tdata;
		ent.fin   = s_tuser;
		ent.quote = s_tdata == cst_pkg::CH_QUOTE;
		ent.sep   = s_tdata == sep;
		ent.lf    = s_tdata == cst_pkg::CH_LF;
		ent.cr    = s_tdata == cst_pkg::CH_CR;
		ent.ws    = cst_pkg::is_ws(s_tdata);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/cst_back.sv
// back end: tokenizer state, sequencer that emits result beats, output register
module cst_back (
	input  logic             clk,
	input  logic             arst_n,
	input  cst_pkg::cfg_t    cfg,
	input  logic             head_valid,
	input  cst_pkg::entry_t  head,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,
	output logic [3:0]       m_tuser,
	output logic             m_tlast
);

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_E4, S_CRUN, S_BOM_A, S_BOM_B, S_HOLD, S_OVF,
		S_HELD, S_CH, S_EC2, S_EC3, S_ER, S_FIN
	} state_t;

	typedef enum logic [1:0] {
		M_PLAIN, M_QUOTED, M_QSEEN, M_AFTER_CR
	} mode_t;

	typedef struct packed {
		logic [2:0]              kind;
		logic [7:0]              b;
		logic [cst_pkg::RUN_W-1:0] count;
		logic                    hdr;
	} res_t;

	state_t                       state_q;
	state_t                       nxt_q;
	mode_t                        mode_q;
	cst_pkg::entry_t              e_q;
	logic                         er_q;
	logic                         rst_q;
	logic                         saw_q;
	logic                         first_q;
	logic                         rec_q;
	logic                         cell_q;
	logic [cst_pkg::RUN_W-1:0]    run_q;
	logic [1:0]                   bom_q;
	logic [7:0]                   held_q [cst_pkg::HOLD_DEPTH];
	logic [cst_pkg::HOLD_CW-1:0]  cnt_q;
	logic [cst_pkg::HOLD_AW-1:0]  hd_q;
	res_t                         pend_q;
	logic                         pend_v_q;
	res_t                         out_q;
	logic                         out_v_q;
	logic                         out_last_q;

	logic                         hdr_act;
	logic                         out_free;
	logic                         can_emit;
	logic                         emit_req;
	logic [2:0]                   e_kind;
	logic [7:0]                   e_byte;
	logic [cst_pkg::RUN_W-1:0]    e_count;
	logic                         go;
	logic [cst_pkg::HOLD_AW:0]    wr_sum;
	logic [cst_pkg::HOLD_AW-1:0]  wr_idx;
	logic [cst_pkg::HOLD_AW-1:0]  hd_inc;
	logic                         held_full;
	logic                         mem_we;
	logic [cst_pkg::HOLD_AW-1:0]  mem_wa;
	logic [7:0]                   bom_exp;
	logic                         bom_cond;
	logic                         deferrable;
	logic                         drop;
	logic                         content_go;

	assign hdr_act   = first_q && cfg.hdr;
	assign out_free  = !out_v_q || m_tready;
	assign can_emit  = !pend_v_q || out_free;
	assign held_full = cnt_q >= cst_pkg::HOLD_CW'(cst_pkg::HOLD_DEPTH);
	assign wr_sum    = {1'b0, hd_q} + (cst_pkg::HOLD_AW+1)'(cnt_q);
	assign wr_idx    = (wr_sum >= (cst_pkg::HOLD_AW+1)'(cst_pkg::HOLD_DEPTH)) ?
		cst_pkg::HOLD_AW'(wr_sum - (cst_pkg::HOLD_AW+1)'(cst_pkg::HOLD_DEPTH)) :
		cst_pkg::HOLD_AW'(wr_sum);
	assign hd_inc    = (hd_q == cst_pkg::HOLD_AW'(cst_pkg::HOLD_DEPTH - 1)) ? '0 :
		hd_q + 1'b1;
	assign bom_cond  = hdr_act && bom_q != 2'd3 && (bom_q != 2'd0 || !cell_q);
	assign deferrable = !cell_q && cfg.skip && !hdr_act && !rec_q;
	assign drop      = cfg.skip && !hdr_act && !rec_q && run_q != '0;
	assign content_go = !(cfg.trim && e_q.ws);
	assign pop       = state_q == S_IDLE && head_valid;

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_q.count, out_q.b};
	assign m_tuser  = {out_q.hdr, out_q.kind};
	assign m_tlast  = out_last_q;

	always_comb begin
		unique case (bom_q)
			2'd0:    bom_exp = cst_pkg::BOM_0;
			2'd1:    bom_exp = cst_pkg::BOM_1;
			default: bom_exp = cst_pkg::BOM_2;
		endcase
	end

	always_comb begin
		emit_req = 1'b0;
		e_kind   = cst_pkg::KIND_BYTE;
		e_byte   = '0;
		e_count  = '0;
		mem_we   = 1'b0;
		mem_wa   = wr_idx;
		unique case (state_q)
			S_E4: begin
				emit_req = 1'b1;
				e_kind   = cst_pkg::KIND_OPENQ;
			end
			S_CRUN: begin
				emit_req = run_q != '0;
				e_kind   = cst_pkg::KIND_RUN;
				e_count  = run_q;
			end
			S_BOM_A: begin
				emit_req = bom_q == 2'd1 || bom_q == 2'd2;
				e_byte   = cst_pkg::BOM_0;
			end
			S_BOM_B: begin
				emit_req = 1'b1;
				e_byte   = cst_pkg::BOM_1;
			end
			S_HOLD: begin
				emit_req = held_full;
				e_kind   = held_full ? cst_pkg::KIND_OVF : cst_pkg::KIND_BYTE;
				mem_we   = !held_full;
			end
			S_OVF: begin
				emit_req = 1'b1;
				e_byte   = held_q[hd_q];
				mem_we   = can_emit;
				mem_wa   = hd_q;
			end
			S_HELD: begin
				emit_req = cnt_q != '0;
				e_byte   = held_q[hd_q];
			end
			S_CH: begin
				emit_req = 1'b1;
				e_byte   = e_q.ch;
			end
			S_EC3: begin
				emit_req = 1'b1;
				if (run_q != '0) begin
					e_kind  = cst_pkg::KIND_RUN;
					e_count = run_q;
				end else begin
					e_kind  = cst_pkg::KIND_CELL;
				end
			end
			S_ER: begin
				emit_req = !drop;
				if (run_q != '0) begin
					e_kind  = cst_pkg::KIND_RUN;
					e_count = run_q;
				end else begin
					e_kind  = cst_pkg::KIND_REC;
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_FIN) begin
			go = !pend_v_q || out_free;
		end else begin
			go = !emit_req || can_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			held_q[mem_wa] <= e_q.ch;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			e_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			nxt_q      <= S_FIN;
			mode_q     <= M_PLAIN;
			er_q       <= 1'b0;
			rst_q      <= 1'b0;
			saw_q      <= 1'b0;
			first_q    <= 1'b1;
			rec_q      <= 1'b0;
			cell_q     <= 1'b0;
			run_q      <= '0;
			bom_q      <= 2'd0;
			cnt_q      <= '0;
			hd_q       <= '0;
			pend_q     <= '0;
			pend_v_q   <= 1'b0;
			out_q      <= '0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			if (emit_req && go) begin
				pend_q.kind  <= e_kind;
				pend_q.b     <= e_byte;
				pend_q.count <= e_count;
				pend_q.hdr   <= hdr_act;
				pend_v_q     <= 1'b1;
				if (pend_v_q) begin
					out_q      <= pend_q;
					out_last_q <= 1'b0;
					out_v_q    <= 1'b1;
				end
			end
			if (go) begin
				unique case (state_q)
					S_IDLE: begin
						if (head_valid) begin
							state_q <= S_DEC;
						end
					end
					S_DEC: begin
						er_q  <= 1'b0;
						rst_q <= 1'b0;
						nxt_q <= S_HELD;
						if (e_q.fin) begin
							rst_q <= 1'b1;
							if (mode_q == M_QUOTED) begin
								state_q <= S_E4;
							end else if (saw_q) begin
								er_q    <= 1'b1;
								nxt_q   <= S_EC2;
								state_q <= S_BOM_A;
							end else begin
								state_q <= S_FIN;
							end
						end else if (mode_q == M_AFTER_CR && e_q.lf) begin
							mode_q  <= M_PLAIN;
							state_q <= S_FIN;
						end else begin
							saw_q <= 1'b1;
							if (mode_q == M_QUOTED && e_q.quote) begin
								mode_q  <= M_QSEEN;
								state_q <= S_FIN;
							end else if (mode_q == M_QUOTED ||
								(mode_q == M_QSEEN && e_q.quote)) begin
								mode_q <= M_QUOTED;
								if (content_go) begin
									state_q <= S_CRUN;
								end else if (!cell_q) begin
									state_q <= S_FIN;
								end else begin
									nxt_q   <= S_HOLD;
									state_q <= S_BOM_A;
								end
							end else begin
								mode_q <= M_PLAIN;
								if (e_q.quote) begin
									mode_q  <= M_QUOTED;
									state_q <= S_FIN;
								end else if (e_q.sep || e_q.lf || e_q.cr) begin
									er_q    <= !e_q.sep;
									nxt_q   <= S_EC2;
									state_q <= S_BOM_A;
									if (!e_q.sep && e_q.cr) begin
										mode_q <= M_AFTER_CR;
									end
								end else if (content_go) begin
									state_q <= S_CRUN;
								end else if (!cell_q) begin
									state_q <= S_FIN;
								end else begin
									nxt_q   <= S_HOLD;
									state_q <= S_BOM_A;
								end
							end
						end
					end
					S_E4: begin
						state_q <= S_FIN;
					end
					S_CRUN: begin
						if (run_q != '0) begin
							run_q <= '0;
						end else begin
							cell_q <= 1'b1;
							rec_q  <= 1'b1;
							if (bom_cond && e_q.ch == bom_exp) begin
								bom_q   <= bom_q + 1'b1;
								state_q <= S_FIN;
							end else begin
								nxt_q   <= S_HELD;
								state_q <= S_BOM_A;
							end
						end
					end
					S_BOM_A: begin
						if (bom_q == 2'd2) begin
							state_q <= S_BOM_B;
						end else begin
							if (bom_q == 2'd1) begin
								bom_q <= 2'd3;
							end
							state_q <= nxt_q;
						end
					end
					S_BOM_B: begin
						bom_q   <= 2'd3;
						state_q <= nxt_q;
					end
					S_HOLD: begin
						if (held_full) begin
							state_q <= S_OVF;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_FIN;
						end
					end
					S_OVF: begin
						hd_q    <= hd_inc;
						state_q <= S_FIN;
					end
					S_HELD: begin
						if (cnt_q != '0) begin
							hd_q  <= hd_inc;
							cnt_q <= cnt_q - 1'b1;
						end else begin
							state_q <= S_CH;
						end
					end
					S_CH: begin
						state_q <= S_FIN;
					end
					S_EC2: begin
						cnt_q <= '0;
						bom_q <= 2'd3;
						if (deferrable) begin
							if (run_q != cst_pkg::RUN_MAX) begin
								run_q <= run_q + 1'b1;
							end
							cell_q  <= 1'b0;
							state_q <= er_q ? S_ER : S_FIN;
						end else begin
							state_q <= S_EC3;
						end
					end
					S_EC3: begin
						if (run_q != '0) begin
							run_q <= '0;
						end else begin
							cell_q  <= 1'b0;
							state_q <= er_q ? S_ER : S_FIN;
						end
					end
					S_ER: begin
						if (!drop && run_q != '0) begin
							run_q <= '0;
						end else begin
							run_q   <= '0;
							first_q <= 1'b0;
							rec_q   <= 1'b0;
							saw_q   <= 1'b0;
							state_q <= S_FIN;
						end
					end
					S_FIN: begin
						if (pend_v_q) begin
							out_q      <= pend_q;
							out_last_q <= 1'b1;
							out_v_q    <= 1'b1;
							pend_v_q   <= 1'b0;
						end
						if (rst_q) begin
							mode_q  <= M_PLAIN;
							saw_q   <= 1'b0;
							first_q <= 1'b1;
							rec_q   <= 1'b0;
							cell_q  <= 1'b0;
							run_q   <= '0;
							cnt_q   <= '0;
							bom_q   <= 2'd0;
						end
						rst_q   <= 1'b0;
						state_q <= S_IDLE;
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

endmodule

FILE: design/csv_stream_tokenizer.sv
// top level of the csv stream tokenizer: configuration registers and the two halves
// path: a beat is queued, popped into the entry register and decoded by the sequencer; each
// result waits in a pending register and goes to the output register with the next or at the end
// one beat is decoded at a time, slowed by output stalls; the four-beat input queue absorbs the rest
// reset: asynchronous, clears queue, tokenizer state and registers to defaults; no clearing pass
module csv_stream_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	input  logic        s_tuser,   // stream_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_byte, empty_run_count
	output logic [3:0]  m_tuser,   // item_kind, is_header
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0]       sep_q;
	cst_pkg::cfg_t    cfg_q;
	logic             head_valid;
	cst_pkg::entry_t  head;
	logic             pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q      <= 8'd44;
			cfg_q.trim <= 1'b0;
			cfg_q.hdr  <= 1'b1;
			cfg_q.skip <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cst_pkg::CFG_SEP:  sep_q      <= cfg_data;
				cst_pkg::CFG_TRIM: cfg_q.trim <= cfg_data[0];
				cst_pkg::CFG_HDR:  cfg_q.hdr  <= cfg_data[0];
				cst_pkg::CFG_SKIP: cfg_q.skip <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	cst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.sep        (sep_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	cst_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
